>>> src/acl_pkg.sv
// Shared types, constants and helpers for the IPv4 first-match ACL.
// No dependencies; imported by every module of the block.
package acl_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PLEN_W        = 6;
  localparam int unsigned MAX_RULES_DEF = 64;

  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

  // input mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // one stored rule
  typedef struct packed {
    logic              deny;
    logic [ADDR_W-1:0] net;
    logic [PLEN_W-1:0] plen;
  } acl_rule_t;

  // controller -> datapath
  typedef struct packed {
    logic load_we;    // append the rule on the input ports
    logic query_cap;  // capture query address, clear pointer, read entry 0
    logic scan_next;  // advance pointer, read next entry
    logic res_ld;     // load verdict into output register
  } acl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // entry under pointer is valid and matches
    logic last;       // no entry after the one under pointer
    logic slot_free;  // output register can take a verdict this cycle
  } acl_sts_t;

  function automatic logic [PLEN_W-1:0] sat_plen(input logic [PLEN_W-1:0] plen);
    sat_plen = (plen > PLEN_MAX) ? PLEN_MAX : plen;
  endfunction

  // plen must already be saturated; zero gives an empty mask
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] ones;
    ones        = '1;
    prefix_mask = (plen == '0) ? '0 : (ones << (PLEN_MAX - plen));
  endfunction

endpackage

>>> src/acl_ctrl.sv
// Controller FSM of the IPv4 first-match ACL: input handshake and scan sequencing.
// Depends on acl_pkg.
module acl_ctrl
  import acl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     mode_i,
  input  acl_sts_t sts_i,
  output acl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        // ready is high throughout idle, so valid alone marks an accepted request
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_QUERY) begin
            cmd_o.query_cap = 1'b1;
            state_d         = ST_SCAN;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          // verdict known; hold here until the output register frees up
          if (sts_i.slot_free) begin
            cmd_o.res_ld = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/acl_dp.sv
// Datapath of the IPv4 first-match ACL: rule memory, rule count, scan pointer,
// match compare and output register. Depends on acl_pkg.
module acl_dp
  import acl_pkg::*;
#(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acl_cmd_t          cmd_i,
  output acl_sts_t          sts_o,
  input  logic              rule_deny_i,
  input  logic [ADDR_W-1:0] rule_address_i,
  input  logic [PLEN_W-1:0] rule_prefix_len_i,
  input  logic [ADDR_W-1:0] query_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              allowed_o,
  output logic              matched_any_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  acl_rule_t mem [MAX_RULES];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  ptr_nxt;
  logic [ADDR_W-1:0] query_q;
  acl_rule_t         rd_q;
  acl_rule_t         wr_rule;
  logic [PLEN_W-1:0] wr_plen;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic              entry_ok;
  logic              match;
  logic              out_valid_q, out_valid_d;
  logic              allowed_q, matched_q;

  // ---- rule append ----
  assign wr_plen      = sat_plen(rule_prefix_len_i);
  assign wr_rule.deny = rule_deny_i;
  assign wr_rule.plen = wr_plen;
  assign wr_rule.net  = rule_address_i & prefix_mask(wr_plen);
  assign wr_en        = cmd_i.load_we && (count_q < CNT_W'(MAX_RULES));
  assign count_d      = wr_en ? count_q + CNT_W'(1) : count_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IDX_W-1:0]] <= wr_rule;
    end
  end

  // ---- scan pointer and registered read ----
  assign ptr_nxt = ptr_q + CNT_W'(1);
  assign rd_en   = cmd_i.query_cap | cmd_i.scan_next;
  assign ptr_d   = cmd_i.query_cap ? '0 : (cmd_i.scan_next ? ptr_nxt : ptr_q);
  assign rd_addr = ptr_d[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (cmd_i.query_cap) begin
      query_q <= query_address_i;
    end
  end

  // ---- compare ----
  assign entry_ok = ptr_q < count_q;
  assign match    = (query_q & prefix_mask(rd_q.plen)) == rd_q.net;

  assign sts_o.hit       = entry_ok & match;
  assign sts_o.last      = ptr_nxt >= count_q;
  assign sts_o.slot_free = ~out_valid_q | out_ready_i;

  // ---- output register ----
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.res_ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      matched_q <= sts_o.hit;
      allowed_q <= sts_o.hit ? ~rd_q.deny : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign allowed_o     = allowed_q;
  assign matched_any_o = matched_q;

endmodule

>>> src/ipv4_prefix_acl_first_match_top.sv
// IPv4 first-match access control list, top level.
// Instantiates acl_ctrl and acl_dp; depends on acl_pkg.
//
// Usage: a request with mode 0 appends a rule (allow/deny action, address,
// prefix length; lengths above 32 act as 32, host bits are cleared on store)
// to an ordered table of MAX_RULES entries; once full, further rule requests
// are dropped. A request with mode 1 classifies query_address: the earliest
// rule whose prefix matches decides allowed, and matched_any is set; with no
// match the verdict is allow with matched_any clear. Rule requests produce no
// result, queries exactly one. A rule is written as its request is taken.
// A query is accepted, then the rules are compared in table order up to
// and including the first match, or up to the last rule; an empty table
// yields the no-match verdict. The rule memory has a single read port,
// so the scan compares one rule per cycle; the next request is taken the
// cycle after the scan ends. The verdict sits in an output register, so
// a new request is accepted while a verdict waits; a scan that finishes
// while the register is still full holds until the consumer takes it.
// No clearing pass is needed after reset.
module ipv4_prefix_acl_first_match_top
  import acl_pkg::*;
#(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic              rule_deny_i,
  input  logic [ADDR_W-1:0] rule_address_i,
  input  logic [PLEN_W-1:0] rule_prefix_len_i,
  input  logic [ADDR_W-1:0] query_address_i,
  // verdict channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              allowed_o,
  output logic              matched_any_o
);

  acl_cmd_t cmd;
  acl_sts_t sts;

  // sequencing: idle/scan FSM
  acl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // rule memory, scan pointer, compare, verdict register
  acl_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rule_deny_i       (rule_deny_i),
    .rule_address_i    (rule_address_i),
    .rule_prefix_len_i (rule_prefix_len_i),
    .query_address_i   (query_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .allowed_o         (allowed_o),
    .matched_any_o     (matched_any_o)
  );

endmodule
